// ===== rtl/core/pcim_pkg.sv =====
// Shared types, constants and the divide-by-five helper for the carrier/integrator mixer.
package pcim_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INTEG_W = 20;
  localparam int unsigned CARR_W  = 18;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned PROD_W  = 62;

  // Input slot numbers, compared against input_count
  localparam logic [CNT_W-1:0] SLOT_SOURCE = 3'd0;
  localparam logic [CNT_W-1:0] SLOT_PLANT  = 3'd1;
  localparam logic [CNT_W-1:0] SLOT_BIAS   = 3'd2;
  localparam logic [CNT_W-1:0] SLOT_GAIN   = 3'd3;
  localparam logic [CNT_W-1:0] SLOT_THRESH = 3'd4;

  // Result field numbers, compared against output_count
  localparam logic [CNT_W-1:0] OUT_ERROR   = 3'd0;
  localparam logic [CNT_W-1:0] OUT_MIX     = 3'd1;
  localparam logic [CNT_W-1:0] OUT_INTEG   = 3'd2;
  localparam logic [CNT_W-1:0] OUT_PULSE   = 3'd3;
  localparam logic [CNT_W-1:0] OUT_CARRIER = 3'd4;

  localparam logic [CNT_W-1:0]  COUNT_RESET  = 3'd5;
  localparam logic [DATA_W-1:0] CARRIER_MULT = 32'd45;
  localparam logic signed [36:0] INTEG_LIMIT = 37'sd262144;
  localparam logic [18:0] CARRIER_ONE = 19'd65536;
  // 5 * 2^31: shifts the mix numerator to a non-negative value, multiple of five
  localparam logic [34:0] MIX_OFFSET  = 35'd10737418240;
  // floor(2^24 / 5)
  localparam logic [21:0] DIV5_RECIP  = 22'd3355443;

  typedef enum logic [1:0] {
    REG_IN_COUNT  = 2'd0,
    REG_OUT_COUNT = 2'd1,
    REG_BIAS      = 2'd2,
    REG_THRESH    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]         in_count;
    logic [CNT_W-1:0]         out_count;
    logic signed [DATA_W-1:0] bias;
    logic signed [DATA_W-1:0] thresh;
  } cfg_t;

  // After the input register: slot-masked samples, clipped step
  typedef struct packed {
    logic signed [DATA_W-1:0] src;
    logic signed [DATA_W-1:0] plant;
    logic signed [DATA_W-1:0] gain;
    logic [STEP_W-1:0]        step_len;
  } s1_t;

  // After the product stage
  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic                     err_neg;
    logic [PROD_W-1:0]        prod;
    logic [DATA_W-1:0]        phase_inc;
    logic signed [DATA_W-1:0] gain;
    logic [13:0]              mix_qa;
    logic [2:0]               mix_ra;
    logic [17:0]              mix_lo;
  } s2_t;

  // After the state stage
  typedef struct packed {
    logic signed [DATA_W-1:0]  err;
    logic signed [DATA_W-1:0]  gain;
    logic signed [INTEG_W-1:0] integ;
    logic signed [CARR_W-1:0]  carrier;
    logic [DATA_W-1:0]         mix_q;
  } s3_t;

  typedef struct packed {
    logic [18:0] q;
    logic [2:0]  r;
  } div5_t;

  // Quotient and remainder of a 21-bit value by five: reciprocal multiply,
  // then one correction step (estimate is never more than one low)
  function automatic div5_t div5(input logic [20:0] x);
    logic [42:0] prod;
    logic [18:0] q0;
    logic [21:0] rem;
    div5_t       res;
    prod = {22'b0, x} * {21'b0, DIV5_RECIP};
    q0   = prod[42:24];
    rem  = {1'b0, x} - ({3'b0, q0} + {1'b0, q0, 2'b00});
    if (rem >= 22'd5) begin
      res.q = q0 + 19'd1;
      res.r = 3'(rem - 22'd5);
    end else begin
      res.q = q0;
      res.r = rem[2:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pcim_in_if.sv =====
// Input channel: one time-step word with valid/ready.
interface pcim_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       source_sample;
  logic signed [31:0]       plant_output;
  logic signed [31:0]       gain_offset;
  logic signed [31:0]       step_length;

  modport source (output valid, source_sample, plant_output, gain_offset, step_length,
                  input ready);
  modport sink   (input valid, source_sample, plant_output, gain_offset, step_length,
                  output ready);
endinterface

// ===== rtl/core/pcim_out_if.sv =====
// Output channel: one result word with valid/ready.
interface pcim_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] error_value;
  logic signed [31:0] mix_value;
  logic signed [19:0] integral_value;
  logic               pulse_bit;
  logic signed [17:0] carrier_value;

  modport source (output valid, error_value, mix_value, integral_value, pulse_bit,
                  carrier_value, input ready);
  modport sink   (input valid, error_value, mix_value, integral_value, pulse_bit,
                  carrier_value, output ready);
endinterface

// ===== rtl/core/pcim_input_stage.sv =====
// Input register: slot masking by input_count and step clipping.
module pcim_input_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcim_pkg::cfg_t      cfg_i,
  pcim_in_if.sink             in_i,
  input  logic                ready_i,
  output logic                valid_o,
  output pcim_pkg::s1_t       data_o
);

  logic          valid_q;
  logic          load;
  pcim_pkg::s1_t data_d, data_q;

  assign in_i.ready = ~valid_q | ready_i;
  assign load       = in_i.valid & in_i.ready;

  // Unconnected slots read as zero; a negative step counts as zero
  always_comb begin
    data_d.src   = (cfg_i.in_count > pcim_pkg::SLOT_SOURCE) ? in_i.source_sample : '0;
    data_d.plant = (cfg_i.in_count > pcim_pkg::SLOT_PLANT)  ? in_i.plant_output  : '0;
    data_d.gain  = (cfg_i.in_count > pcim_pkg::SLOT_GAIN)   ? in_i.gain_offset   : '0;
    data_d.step_len = in_i.step_length[31] ? '0 : in_i.step_length[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/pcim_arith_stage.sv =====
// Product stage: saturated error, error*step product, phase increment, mix division front half.
module pcim_arith_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  pcim_pkg::s1_t data_i,
  output logic          ready_o,
  input  logic          ready_i,
  output logic          valid_o,
  output pcim_pkg::s2_t data_o
);

  logic          valid_q;
  logic          load;
  logic [32:0]   diff;
  logic [31:0]   err;
  logic [31:0]   emag;
  logic [34:0]   src_x, plant_x, num, ushift;
  pcim_pkg::div5_t hi_div;
  pcim_pkg::s2_t data_d, data_q;

  assign ready_o = ~valid_q | ready_i;
  assign load    = valid_i & ready_o;

  // Error, saturated to 32 bits
  always_comb begin
    diff = {data_i.src[31], data_i.src} - {data_i.plant[31], data_i.plant};
    if (diff[32] != diff[31]) begin
      err = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      err = diff[31:0];
    end
    emag = err[31] ? (~err + 32'd1) : err;
  end

  // Mix numerator 3*src + 2*plant, rounded quotient = floor((num + 2) / 5);
  // offset keeps it non-negative, then split into high and low digits
  always_comb begin
    src_x   = {{3{data_i.src[31]}}, data_i.src};
    plant_x = {{3{data_i.plant[31]}}, data_i.plant};
    num     = (src_x << 1) + src_x + (plant_x << 1);
    ushift  = num + 35'd2 + pcim_pkg::MIX_OFFSET;
    hi_div  = pcim_pkg::div5({4'b0, ushift[34:18]});
  end

  always_comb begin
    data_d.err       = err;
    data_d.err_neg   = err[31];
    data_d.prod      = 62'(emag) * 62'(data_i.step_len);
    data_d.phase_inc = {1'b0, data_i.step_len} * pcim_pkg::CARRIER_MULT;
    data_d.gain      = data_i.gain;
    data_d.mix_qa    = hi_div.q[13:0];
    data_d.mix_ra    = hi_div.r;
    data_d.mix_lo    = ushift[17:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/pcim_state_stage.sv =====
// State stage: clamped integrator, carrier phase accumulator, triangle, mix division back half.
module pcim_state_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  pcim_pkg::s2_t data_i,
  output logic          ready_o,
  input  logic          ready_i,
  output logic          valid_o,
  output pcim_pkg::s3_t data_o
);

  logic               valid_q;
  logic               load;
  logic [64:0]        prod5;
  logic [34:0]        inc;
  logic signed [36:0] integ_ext, integ_sum;
  logic signed [19:0] integ_d, integ_q;
  logic [31:0]        phase_d, phase_q;
  logic [31:0]        phase_neg;
  logic [17:0]        tri_mag;
  logic [18:0]        carrier_x;
  pcim_pkg::div5_t    lo_div;
  pcim_pkg::s3_t      data_d, data_q;

  assign ready_o = ~valid_q | ready_i;
  assign load    = valid_i & ready_o;

  // Increment = floor(5 * |e| * d / 2^30), applied with the error's sign, then clamped
  always_comb begin
    prod5     = {3'b0, data_i.prod} + {1'b0, data_i.prod, 2'b00};
    inc       = prod5[64:30];
    integ_ext = {{17{integ_q[19]}}, integ_q};
    integ_sum = data_i.err_neg ? (integ_ext - {2'b0, inc}) : (integ_ext + {2'b0, inc});
    if (integ_sum > pcim_pkg::INTEG_LIMIT) begin
      integ_d = 20'(pcim_pkg::INTEG_LIMIT);
    end else if (integ_sum < -pcim_pkg::INTEG_LIMIT) begin
      integ_d = 20'(-pcim_pkg::INTEG_LIMIT);
    end else begin
      integ_d = integ_sum[19:0];
    end
  end

  // Phase wraps mod 2^32; triangle folds at half a turn
  always_comb begin
    phase_d   = phase_q + data_i.phase_inc;
    phase_neg = 32'd0 - phase_d;
    tri_mag   = phase_d[31] ? phase_neg[31:14] : {1'b0, phase_d[30:14]};
    carrier_x = {1'b0, tri_mag} - pcim_pkg::CARRIER_ONE;
  end

  // Low digit of the mix division
  always_comb begin
    lo_div = pcim_pkg::div5({data_i.mix_ra, data_i.mix_lo});
  end

  always_comb begin
    data_d.err     = data_i.err;
    data_d.gain    = data_i.gain;
    data_d.integ   = integ_d;
    data_d.carrier = carrier_x[17:0];
    data_d.mix_q   = {data_i.mix_qa, lo_div.q[17:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
      phase_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        integ_q <= integ_d;
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Integrator never leaves +/-4.0
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= 20'sd262144) && (integ_q >= -20'sd262144))
    else $error("integrator out of range");

  // State moves only when a word enters this stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> ($stable(integ_q) && $stable(phase_q)))
    else $error("state changed without a word");

  // A zero step leaves both accumulators untouched
  a_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && data_i.prod == '0 && data_i.phase_inc == '0)
      |=> ($stable(integ_q) && $stable(phase_q)))
    else $error("zero step advanced state");

endmodule

// ===== rtl/core/pcim_output_stage.sv =====
// Output register: mix bias and saturation, pulse compare, output_count masking.
module pcim_output_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcim_pkg::cfg_t cfg_i,
  input  logic           valid_i,
  input  pcim_pkg::s3_t  data_i,
  output logic           ready_o,
  pcim_out_if.source     out_o
);

  logic               valid_q;
  logic               load;
  logic signed [31:0] bias_eff, thr_eff;
  logic signed [31:0] mix_base;
  logic signed [32:0] mix_sum;
  logic signed [31:0] mix_sat;
  logic signed [32:0] lhs, rhs;
  logic               pulse;
  logic signed [31:0] err_d, mix_d;
  logic signed [19:0] integ_d;
  logic               pulse_d;
  logic signed [17:0] carrier_d;
  logic signed [31:0] err_q, mix_q;
  logic signed [19:0] integ_q;
  logic               pulse_q;
  logic signed [17:0] carrier_q;

  assign ready_o = ~valid_q | out_o.ready;
  assign load    = valid_i & ready_o;

  // Mix: remove the division offset, add bias, saturate
  always_comb begin
    bias_eff = (cfg_i.in_count > pcim_pkg::SLOT_BIAS)   ? cfg_i.bias   : '0;
    thr_eff  = (cfg_i.in_count > pcim_pkg::SLOT_THRESH) ? cfg_i.thresh : '0;
    mix_base = {~data_i.mix_q[31], data_i.mix_q[30:0]};
    mix_sum  = {mix_base[31], mix_base} + {bias_eff[31], bias_eff};
    if (mix_sum[32] != mix_sum[31]) begin
      mix_sat = mix_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      mix_sat = mix_sum[31:0];
    end
  end

  // Pulse compare at full width
  always_comb begin
    lhs   = {data_i.err[31], data_i.err} + {data_i.gain[31], data_i.gain};
    rhs   = {{15{data_i.carrier[17]}}, data_i.carrier} + {thr_eff[31], thr_eff};
    pulse = lhs > rhs;
  end

  // Undriven result fields are zero
  always_comb begin
    err_d     = (cfg_i.out_count > pcim_pkg::OUT_ERROR)   ? data_i.err     : '0;
    mix_d     = (cfg_i.out_count > pcim_pkg::OUT_MIX)     ? mix_sat        : '0;
    integ_d   = (cfg_i.out_count > pcim_pkg::OUT_INTEG)   ? data_i.integ   : '0;
    pulse_d   = (cfg_i.out_count > pcim_pkg::OUT_PULSE)   ? pulse          : 1'b0;
    carrier_d = (cfg_i.out_count > pcim_pkg::OUT_CARRIER) ? data_i.carrier : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q     <= err_d;
      mix_q     <= mix_d;
      integ_q   <= integ_d;
      pulse_q   <= pulse_d;
      carrier_q <= carrier_d;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.error_value    = err_q;
  assign out_o.mix_value      = mix_q;
  assign out_o.integral_value = integ_q;
  assign out_o.pulse_bit      = pulse_q;
  assign out_o.carrier_value  = carrier_q;

endmodule

// ===== rtl/core/pwm_carrier_integrator_mixer.sv =====
// Top level: config registers and the four-register datapath of the carrier/integrator mixer.
//
// Usage:
//   in_i carries one time-step word (source, plant output, gain offset, step length);
//   out_o returns one result word per input word, in order (error, mix, integral,
//   pulse, carrier). Both are valid/ready; a word moves when both are high.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 input_count, 1 output_count, 2 bias_offset, 3 comparator_threshold);
//   write only while no word is in flight.
//   Path: an accepted word passes through the input, product, state and output
//   registers in that order before it is presented on out_o.
//   Throughput: one word per cycle while out_o is ready. Integrator add/clamp and phase add
//   each close a loop in the state register, so words may follow back to back.
//   Stall: each register stage holds its word while the next one cannot take it, and
//   empty stages behind a stalled output keep taking words until all four fill.
//   Reset: integrator and phase clear to zero, both counts to five, bias and
//   threshold to zero, and all stages empty.
module pwm_carrier_integrator_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcim_in_if.sink     in_i,
  pcim_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [2:0]         in_count_q, out_count_q;
  logic signed [31:0] bias_q, thresh_q;
  pcim_pkg::cfg_t     cfg;

  logic          s1_valid, s2_valid, s3_valid;
  logic          s2_ready, s3_ready, s4_ready;
  pcim_pkg::s1_t s1_data;
  pcim_pkg::s2_t s2_data;
  pcim_pkg::s3_t s3_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= pcim_pkg::COUNT_RESET;
      out_count_q <= pcim_pkg::COUNT_RESET;
      bias_q      <= '0;
      thresh_q    <= '0;
    end else if (cfg_we_i) begin
      case (pcim_pkg::reg_idx_e'(cfg_index_i))
        pcim_pkg::REG_IN_COUNT:  in_count_q  <= cfg_wdata_i[2:0];
        pcim_pkg::REG_OUT_COUNT: out_count_q <= cfg_wdata_i[2:0];
        pcim_pkg::REG_BIAS:      bias_q      <= cfg_wdata_i;
        pcim_pkg::REG_THRESH:    thresh_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.in_count  = in_count_q;
    cfg.out_count = out_count_q;
    cfg.bias      = bias_q;
    cfg.thresh    = thresh_q;
  end

  pcim_input_stage u_input (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_i    (in_i),
    .ready_i (s2_ready),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  pcim_arith_stage u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s2_ready),
    .ready_i (s3_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  pcim_state_stage u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_o (s3_ready),
    .ready_i (s4_ready),
    .valid_o (s3_valid),
    .data_o  (s3_data)
  );

  pcim_output_stage u_output (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s3_valid),
    .data_i  (s3_data),
    .ready_o (s4_ready),
    .out_o   (out_o)
  );

endmodule
